// ===== hdl/tirp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tirp_pkg
// Shared types and codes of the tape image record parser.
// ----------------------------------------------------------------------------
package tirp_pkg;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_DATA,
        PH_TRAIL,
        PH_PAD,
        PH_DONE,
        PH_ERR
    } phase_t;

    localparam logic [2:0] EV_DATA        = 3'd0;
    localparam logic [2:0] EV_MARK        = 3'd1;
    localparam logic [2:0] EV_GAP         = 3'd2;
    localparam logic [2:0] EV_REC         = 3'd3;
    localparam logic [2:0] EV_EOM         = 3'd4;
    localparam logic [2:0] EV_EOM_MISSING = 3'd5;
    localparam logic [2:0] EV_ERR         = 3'd6;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MARKER    = 3'd1;
    localparam logic [2:0] ERR_ZERO_LEN  = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
    localparam logic [2:0] ERR_NO_TRAIL  = 3'd4;
    localparam logic [2:0] ERR_EARLY_EOF = 3'd5;

    localparam logic [31:0] MARK_EOM  = 32'hffff_ffff;
    localparam logic [31:0] MARK_GAP  = 32'hffff_fffe;
    localparam logic [31:0] MARK_TAPE = 32'h0000_0000;

    localparam int CNT_W   = 24;
    localparam int LIMIT_W = 25;

    typedef struct packed {
        logic               valid;
        logic [2:0]         event_code;
        logic [7:0]         data;
        logic               last;
        logic               bad;
        logic [CNT_W-1:0]   length;
        logic [CNT_W-1:0]   count;
        logic [2:0]         error;
    } res_t;

endpackage
`default_nettype wire

// ===== hdl/tirp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tirp_step
// Next-state and result logic for one byte beat of the tape image parser.
// ----------------------------------------------------------------------------
module tirp_step
    import tirp_pkg::*;
#(
    parameter int LENGTH_BITS   = 24,
    parameter int MAX_PAD_BYTES = 4
)
(
    input  wire phase_t                  phase_reg,
    input  wire logic [31:0]             marker_reg,
    input  wire logic [1:0]              mcount_reg,
    input  wire logic [LENGTH_BITS-1:0]  cur_len_reg,
    input  wire logic [LENGTH_BITS-1:0]  remain_reg,
    input  wire logic [((MAX_PAD_BYTES < 2) ? 1 : $clog2(MAX_PAD_BYTES + 1))-1:0] pad_reg,
    input  wire logic                    bad_reg,
    input  wire logic [CNT_W-1:0]        done_reg,
    input  wire logic [2:0]              herr_reg,
    input  wire logic [LIMIT_W-1:0]      limit,
    input  wire logic [7:0]              in_byte,
    input  wire logic                    end_of_file,
    output phase_t                       phase_next,
    output logic [31:0]                  marker_next,
    output logic [1:0]                   mcount_next,
    output logic [LENGTH_BITS-1:0]       cur_len_next,
    output logic [LENGTH_BITS-1:0]       remain_next,
    output logic [((MAX_PAD_BYTES < 2) ? 1 : $clog2(MAX_PAD_BYTES + 1))-1:0] pad_next,
    output logic                         bad_next,
    output logic [CNT_W-1:0]             done_next,
    output logic [2:0]                   herr_next,
    output res_t                         res
);

    localparam int PAD_W = (MAX_PAD_BYTES < 2) ? 1 : $clog2(MAX_PAD_BYTES + 1);

    logic [31:0]            shifted;
    logic [LENGTH_BITS-1:0] marker_len;
    logic                   len_match;
    logic                   reserved_set;
    logic                   too_long;
    logic [LENGTH_BITS-1:0] remain_dec;
    logic [PAD_W-1:0]       pad_inc;
    logic                   pad_spent;
    logic                   marker_full;

    assign shifted      = {in_byte, marker_reg[31:8]};
    assign marker_len   = shifted[LENGTH_BITS-1:0];
    assign len_match    = (marker_len == cur_len_reg);
    assign reserved_set = (shifted[30:LENGTH_BITS] != '0);
    assign too_long     = (LIMIT_W'(marker_len) >= limit);
    assign remain_dec   = remain_reg - LENGTH_BITS'(1);
    assign pad_inc      = pad_reg + PAD_W'(1);
    assign pad_spent    = (pad_inc >= PAD_W'(MAX_PAD_BYTES));
    assign marker_full  = (mcount_reg == 2'd3);

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        marker_next  = marker_reg;
        mcount_next  = mcount_reg;
        cur_len_next = cur_len_reg;
        remain_next  = remain_reg;
        pad_next     = pad_reg;
        bad_next     = bad_reg;
        done_next    = done_reg;
        herr_next    = herr_reg;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (end_of_file)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    marker_next = shifted;
                    if (!marker_full)
                    begin
                        mcount_next = mcount_reg + 2'd1;
                    end
                    else
                    begin
                        mcount_next = 2'd0;
                        priority if (shifted == MARK_EOM)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (shifted == MARK_GAP || shifted == MARK_TAPE)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else if (reserved_set)
                        begin
                            phase_next = PH_ERR;
                            herr_next  = ERR_MARKER;
                        end
                        else if (marker_len == '0)
                        begin
                            phase_next = PH_ERR;
                            herr_next  = ERR_ZERO_LEN;
                        end
                        else if (too_long)
                        begin
                            phase_next = PH_ERR;
                            herr_next  = ERR_TOO_LONG;
                        end
                        else
                        begin
                            cur_len_next = marker_len;
                            remain_next  = marker_len;
                            bad_next     = shifted[31];
                            phase_next   = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                if (end_of_file)
                begin
                    phase_next = PH_ERR;
                    herr_next  = ERR_EARLY_EOF;
                end
                else
                begin
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        phase_next  = PH_TRAIL;
                        mcount_next = 2'd0;
                    end
                end
            end
            PH_TRAIL:
            begin
                if (end_of_file)
                begin
                    phase_next = PH_ERR;
                    herr_next  = ERR_EARLY_EOF;
                end
                else
                begin
                    marker_next = shifted;
                    if (!marker_full)
                    begin
                        mcount_next = mcount_reg + 2'd1;
                    end
                    else
                    begin
                        mcount_next = 2'd0;
                        priority if (len_match)
                        begin
                            done_next  = done_reg + CNT_W'(1);
                            phase_next = PH_LEAD;
                            pad_next   = '0;
                        end
                        else if (MAX_PAD_BYTES == 0)
                        begin
                            phase_next = PH_ERR;
                            herr_next  = ERR_NO_TRAIL;
                        end
                        else
                        begin
                            pad_next   = '0;
                            phase_next = PH_PAD;
                        end
                    end
                end
            end
            PH_PAD:
            begin
                if (end_of_file)
                begin
                    phase_next = PH_ERR;
                    herr_next  = ERR_EARLY_EOF;
                end
                else
                begin
                    marker_next = shifted;
                    pad_next    = pad_inc;
                    priority if (len_match)
                    begin
                        done_next   = done_reg + CNT_W'(1);
                        phase_next  = PH_LEAD;
                        mcount_next = 2'd0;
                        pad_next    = '0;
                    end
                    else if (pad_spent)
                    begin
                        phase_next = PH_ERR;
                        herr_next  = ERR_NO_TRAIL;
                    end
                    else
                    begin
                        phase_next = PH_PAD;
                    end
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            PH_ERR:
            begin
                phase_next = PH_ERR;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Result of this beat
    always_comb
    begin
        res            = '0;
        res.event_code = EV_DATA;
        res.count      = done_next;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (end_of_file)
                begin
                    res.valid      = 1'b1;
                    res.event_code = EV_EOM_MISSING;
                end
                else if (marker_full)
                begin
                    res.valid = 1'b1;
                    priority if (shifted == MARK_EOM)
                    begin
                        res.event_code = EV_EOM;
                    end
                    else if (shifted == MARK_GAP)
                    begin
                        res.event_code = EV_GAP;
                    end
                    else if (shifted == MARK_TAPE)
                    begin
                        res.event_code = EV_MARK;
                    end
                    else if (reserved_set)
                    begin
                        res.event_code = EV_ERR;
                        res.error      = ERR_MARKER;
                    end
                    else if (marker_len == '0)
                    begin
                        res.event_code = EV_ERR;
                        res.error      = ERR_ZERO_LEN;
                    end
                    else if (too_long)
                    begin
                        res.event_code = EV_ERR;
                        res.error      = ERR_TOO_LONG;
                    end
                    else
                    begin
                        res.valid = 1'b0;
                    end
                end
            end
            PH_DATA:
            begin
                res.valid = 1'b1;
                if (end_of_file)
                begin
                    res.event_code = EV_ERR;
                    res.error      = ERR_EARLY_EOF;
                end
                else
                begin
                    res.event_code = EV_DATA;
                    res.data       = in_byte;
                    res.last       = (remain_dec == '0);
                    res.bad        = bad_reg;
                end
            end
            PH_TRAIL:
            begin
                if (end_of_file)
                begin
                    res.valid      = 1'b1;
                    res.event_code = EV_ERR;
                    res.error      = ERR_EARLY_EOF;
                end
                else if (marker_full)
                begin
                    priority if (len_match)
                    begin
                        res.valid      = 1'b1;
                        res.event_code = EV_REC;
                        res.bad        = bad_reg;
                        res.length     = CNT_W'(cur_len_reg);
                    end
                    else if (MAX_PAD_BYTES == 0)
                    begin
                        res.valid      = 1'b1;
                        res.event_code = EV_ERR;
                        res.error      = ERR_NO_TRAIL;
                    end
                    else
                    begin
                        res.valid = 1'b0;
                    end
                end
            end
            PH_PAD:
            begin
                if (end_of_file)
                begin
                    res.valid      = 1'b1;
                    res.event_code = EV_ERR;
                    res.error      = ERR_EARLY_EOF;
                end
                else
                begin
                    priority if (len_match)
                    begin
                        res.valid      = 1'b1;
                        res.event_code = EV_REC;
                        res.bad        = bad_reg;
                        res.length     = CNT_W'(cur_len_reg);
                    end
                    else if (pad_spent)
                    begin
                        res.valid      = 1'b1;
                        res.event_code = EV_ERR;
                        res.error      = ERR_NO_TRAIL;
                    end
                    else
                    begin
                        res.valid = 1'b0;
                    end
                end
            end
            PH_ERR:
            begin
                res.valid      = 1'b1;
                res.event_code = EV_ERR;
                res.error      = herr_reg;
            end
            PH_DONE:
            begin
                res.valid = 1'b0;
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/tape_image_record_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each result is registered: it appears in the cycle after the input beat that causes it.
// Throughput: one input byte per clock unless an untaken result holds in_ready low.
// The output register lets a new input beat be taken in the cycle the previous result is taken.
// Reset (rst_n low, asynchronous): parser waits for a leading marker, counters and
// errors clear, limit_reg returns to 65536, no result pending.
// ----------------------------------------------------------------------------
// tape_image_record_parser_top
// Parses a tape image byte stream into markers, record bytes, record ends and errors.
// ----------------------------------------------------------------------------
module tape_image_record_parser_top
    import tirp_pkg::*;
#(
    parameter int LENGTH_BITS   = 24,
    parameter int MAX_PAD_BYTES = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [LIMIT_W-1:0]  cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          in_byte,
    input  wire logic                end_of_file,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               event_res,
    output logic [7:0]               data_byte,
    output logic                     last_in_record,
    output logic                     record_bad,
    output logic [CNT_W-1:0]         record_length,
    output logic [CNT_W-1:0]         record_count,
    output logic [2:0]               error_code
);

    localparam int PAD_W = (MAX_PAD_BYTES < 2) ? 1 : $clog2(MAX_PAD_BYTES + 1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

    // Parser state
    phase_t                  phase_reg,  phase_next;
    logic [31:0]             marker_reg, marker_next;
    logic [1:0]              mcount_reg, mcount_next;
    logic [LENGTH_BITS-1:0]  cur_len_reg, cur_len_next;
    logic [LENGTH_BITS-1:0]  remain_reg, remain_next;
    logic [PAD_W-1:0]        pad_reg, pad_next;
    logic                    bad_reg, bad_next;
    logic [CNT_W-1:0]        done_reg, done_next;
    logic [2:0]              herr_reg, herr_next;
    logic [LIMIT_W-1:0]      limit_reg;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    res_t                    out_reg;
    res_t                    step_res;
    logic                    in_beat;

    // Take a new beat whenever the output slot is empty or draining this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_beat  = in_valid && in_ready;

    tirp_step #(
        .LENGTH_BITS   (LENGTH_BITS),
        .MAX_PAD_BYTES (MAX_PAD_BYTES)
    ) u_step (
        .phase_reg    (phase_reg),
        .marker_reg   (marker_reg),
        .mcount_reg   (mcount_reg),
        .cur_len_reg  (cur_len_reg),
        .remain_reg   (remain_reg),
        .pad_reg      (pad_reg),
        .bad_reg      (bad_reg),
        .done_reg     (done_reg),
        .herr_reg     (herr_reg),
        .limit        (limit_reg),
        .in_byte      (in_byte),
        .end_of_file  (end_of_file),
        .phase_next   (phase_next),
        .marker_next  (marker_next),
        .mcount_next  (mcount_next),
        .cur_len_next (cur_len_next),
        .remain_next  (remain_next),
        .pad_next     (pad_next),
        .bad_next     (bad_next),
        .done_next    (done_next),
        .herr_next    (herr_next),
        .res          (step_res)
    );

    // Configuration: record length limit; write it only while idle (the block does not enforce this).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Advance parser state on each accepted beat; hold otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            marker_reg  <= '0;
            mcount_reg  <= '0;
            cur_len_reg <= '0;
            remain_reg  <= '0;
            pad_reg     <= '0;
            bad_reg     <= 1'b0;
            done_reg    <= '0;
            herr_reg    <= ERR_NONE;
        end
        else if (in_beat)
        begin
            phase_reg   <= phase_next;
            marker_reg  <= marker_next;
            mcount_reg  <= mcount_next;
            cur_len_reg <= cur_len_next;
            remain_reg  <= remain_next;
            pad_reg     <= pad_next;
            bad_reg     <= bad_next;
            done_reg    <= done_next;
            herr_reg    <= herr_next;
        end
    end

    // Result slot: fill on a beat that yields a result, drop once taken.
    always_comb
    begin
        if (in_beat && step_res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && step_res.valid)
        begin
            out_reg <= step_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = out_reg.event_code;
    assign data_byte      = out_reg.data;
    assign last_in_record = out_reg.last;
    assign record_bad     = out_reg.bad;
    assign record_length  = out_reg.length;
    assign record_count   = out_reg.count;
    assign error_code     = out_reg.error;

    // A parser in the error phase always carries a nonzero error code.
    a_err_code_held : assert property (
        @(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERR) |-> (herr_reg != ERR_NONE)
    ) else $error("error phase without an error code");

    // Error codes only travel with error events.
    a_err_only_on_err : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res != EV_ERR)) |-> (error_code == ERR_NONE)
    ) else $error("error code on a non-error event");

    // End of record flag only on data bytes.
    a_last_on_data : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && last_in_record) |-> (event_res == EV_DATA)
    ) else $error("last_in_record on a non-data event");

    // A record end bumps the running count by one.
    a_count_step : assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_beat && step_res.valid && (step_res.event_code == EV_REC))
            |-> (step_res.count == done_reg + CNT_W'(1))
    ) else $error("record count did not advance on record end");

endmodule
`default_nettype wire
